[src/adjacency_matrix_graph_engine_macros.svh]
// Assertion macros for the adjacency matrix graph engine.
`ifndef ADJACENCY_MATRIX_GRAPH_ENGINE_MACROS_SVH
`define ADJACENCY_MATRIX_GRAPH_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define AMGE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define AMGE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/amge_pkg.sv]
// Shared types and constants of the adjacency matrix graph engine.
package amge_pkg;

  // Default sizes
  localparam int MAX_VERTICES_DEF = 16;
  localparam int WEIGHT_BITS_DEF  = 16;

  // Fixed field widths of the request and result
  localparam int VERTEX_BITS = 5;
  localparam int DEGREE_BITS = 5;
  localparam int TOTAL_BITS  = 9;

  // Configuration port
  localparam int PADDR_BITS = 3;
  localparam int PDATA_BITS = 32;
  localparam logic [PADDR_BITS-3:0] REG_VERTEX_COUNT = '0;
  localparam logic [VERTEX_BITS-1:0] VERTEX_COUNT_RESET = 5'd16;

  // Request operations
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DEGREE = 2'd1,
    OP_LIST   = 2'd2,
    OP_CONN   = 2'd3
  } op_t;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_DEGREE = 3'd0,
    KIND_OUT_NB = 3'd1,
    KIND_IN_NB  = 3'd2,
    KIND_END    = 3'd3,
    KIND_CONN   = 3'd4,
    KIND_ERROR  = 3'd5
  } kind_t;

  typedef struct packed {
    logic [1:0]             operation;
    logic [VERTEX_BITS-1:0] first_vertex;
    logic [VERTEX_BITS-1:0] second_vertex;
    logic signed [15:0]     weight;
  } req_t;

  typedef struct packed {
    logic [2:0]             kind;
    logic [VERTEX_BITS-1:0] vertex;
    logic [DEGREE_BITS-1:0] out_degree;
    logic [DEGREE_BITS-1:0] in_degree;
    logic [TOTAL_BITS-1:0]  total_out;
    logic [TOTAL_BITS-1:0]  total_in;
    logic                   connected;
    logic                   last;
  } res_t;

endpackage

[src/adjacency_matrix_graph_engine.sv]
// Request steps: an insert writes on acceptance; a connection check reads the pair
// and drains; a bad vertex gives an error result; a neighbor list scans the row,
// the column and marks the end; a degree report scans n*n entries and drains, n
// being the vertex count in use. One entry pair is read per cycle; a stalled result
// holds the scan. Reset: vertex_count returns to 16 and a clearing pass zeroes all
// 2**(2*ceil(log2(MAX_VERTICES))) store entries (256 by default), taking no request.
module adjacency_matrix_graph_engine #(
  parameter int MAX_VERTICES = amge_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = amge_pkg::WEIGHT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  amge_pkg::req_t                   req,
  output logic                             res_valid,
  input  logic                             res_stall,
  output amge_pkg::res_t                   res,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [amge_pkg::PADDR_BITS-1:0]  paddr,
  input  logic [amge_pkg::PDATA_BITS-1:0]  pwdata,
  output logic [amge_pkg::PDATA_BITS-1:0]  prdata,
  output logic                             pready
);
  import amge_pkg::*;

  localparam int IW    = $clog2(MAX_VERTICES);
  localparam int VW    = $clog2(MAX_VERTICES + 1);
  localparam int CW    = (VW > VERTEX_BITS) ? VW : VERTEX_BITS;
  localparam int TW    = $clog2(MAX_VERTICES * MAX_VERTICES + 1);
  localparam int TCW   = (TW > TOTAL_BITS) ? TW : TOTAL_BITS;
  localparam int AW    = 2 * IW;
  localparam int DEPTH = 1 << AW;

  typedef enum logic [8:0] {
    ST_CLEAR  = 9'b000000001,
    ST_IDLE   = 9'b000000010,
    ST_DEGREE = 9'b000000100,
    ST_OUT    = 9'b000001000,
    ST_IN     = 9'b000010000,
    ST_CONN   = 9'b000100000,
    ST_DRAIN  = 9'b001000000,
    ST_MARK   = 9'b010000000,
    ST_ERROR  = 9'b100000000
  } state_t;

  typedef enum logic [1:0] {
    P_DEG  = 2'd0,
    P_OUT  = 2'd1,
    P_IN   = 2'd2,
    P_CONN = 2'd3
  } pass_t;

  state_t state, state_next;

  // Control registers
  logic [VERTEX_BITS-1:0] vertex_count;
  logic [AW-1:0]          clr_addr;
  logic                   s2_valid;

  // Scan position and item context
  logic [IW-1:0]          row, col;
  logic [VERTEX_BITS-1:0] item_vtx;
  pass_t                  s2_pass;
  logic [IW-1:0]          s2_row, s2_col;
  logic                   s2_row_end, s2_all_end;
  logic [VW-1:0]          od_acc, id_acc;
  logic [TW-1:0]          tot_out, tot_in;

  // Weight store
  logic [WEIGHT_BITS-1:0] mem [DEPTH];
  logic [WEIGHT_BITS-1:0] rd_a, rd_b;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [WEIGHT_BITS-1:0] mem_wdata;

  logic                   go, accept, cfg_write, scanning;
  pass_t                  scan_pass;
  logic [CW-1:0]          vc_ext, n_c, a_ext, b_ext;
  logic [VW-1:0]          n, n_m1;
  logic                   va, vb, col_end, row_end;
  logic [IW-1:0]          idx_a, idx_b;
  logic signed [31:0]     w_ext;
  logic                   nz_a, nz_b, emit;
  res_t                   emit_res;
  logic [VW-1:0]          od_sum, id_sum;
  logic [TW-1:0]          tot_out_sum, tot_in_sum;
  logic [CW-1:0]          od_x, id_x, row_x, col_x;
  logic [TCW-1:0]         tot_out_x, tot_in_x;

  // Handshakes
  assign go        = !res_valid || !res_stall;
  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[PADDR_BITS-1:2] == REG_VERTEX_COUNT)
                     ? PDATA_BITS'(vertex_count) : '0;

  // Effective vertex count, clamped to 1..MAX_VERTICES
  always_comb begin
    vc_ext = CW'(vertex_count);
    if (vc_ext == '0) begin
      n_c = CW'(1);
    end else if (vc_ext > CW'(MAX_VERTICES)) begin
      n_c = CW'(MAX_VERTICES);
    end else begin
      n_c = vc_ext;
    end
    n    = VW'(n_c);
    n_m1 = n - VW'(1);
  end

  // Request vertex checks and 0-based indexes
  assign a_ext = CW'(req.first_vertex);
  assign b_ext = CW'(req.second_vertex);
  assign va    = (a_ext != '0) && (a_ext <= n_c);
  assign vb    = (b_ext != '0) && (b_ext <= n_c);
  assign idx_a = IW'(a_ext - CW'(1));
  assign idx_b = IW'(b_ext - CW'(1));
  assign w_ext = 32'(req.weight);

  assign col_end = (VW'(col) == n_m1);
  assign row_end = (VW'(row) == n_m1);

  // Which states issue a store read, and what the read is for
  always_comb begin
    scanning  = 1'b0;
    scan_pass = P_DEG;
    unique case (state) inside
      ST_DEGREE: begin
        scanning = 1'b1;
      end
      ST_OUT: begin
        scanning  = 1'b1;
        scan_pass = P_OUT;
      end
      ST_IN: begin
        scanning  = 1'b1;
        scan_pass = P_IN;
      end
      ST_CONN: begin
        scanning  = 1'b1;
        scan_pass = P_CONN;
      end
      ST_CLEAR, ST_IDLE, ST_DRAIN, ST_MARK, ST_ERROR: begin
        scanning = 1'b0;
      end
      default: begin
        scanning = 1'b0;
      end
    endcase
  end

  // Store write: clearing pass or insert
  always_comb begin
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = accept && (req.operation == OP_INSERT) && va && vb;
      mem_waddr = {idx_a, idx_b};
      mem_wdata = w_ext[WEIGHT_BITS-1:0];
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == '1) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) begin
          unique case (req.operation)
            OP_INSERT: if (!(va && vb)) state_next = ST_ERROR;
            OP_DEGREE: state_next = ST_DEGREE;
            OP_LIST:   state_next = va ? ST_OUT : ST_ERROR;
            OP_CONN:   state_next = (va && vb) ? ST_CONN : ST_ERROR;
            default:   state_next = ST_ERROR;
          endcase
        end
      end
      ST_DEGREE: begin
        if (go && col_end && row_end) state_next = ST_DRAIN;
      end
      ST_OUT: begin
        if (go && col_end) state_next = ST_IN;
      end
      ST_IN: begin
        if (go && col_end) state_next = ST_MARK;
      end
      ST_CONN: begin
        if (go) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (go) state_next = ST_IDLE;
      end
      ST_MARK: begin
        if (go && !s2_valid) state_next = ST_IDLE;
      end
      ST_ERROR: begin
        if (go) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Evaluate the entry pair read last step and build the result
  always_comb begin
    nz_a        = |rd_a;
    nz_b        = |rd_b;
    od_sum      = od_acc + VW'(nz_a);
    id_sum      = id_acc + VW'(nz_b);
    tot_out_sum = tot_out + TW'(od_sum);
    tot_in_sum  = tot_in + TW'(id_sum);
    od_x        = CW'(od_sum);
    id_x        = CW'(id_sum);
    row_x       = CW'(s2_row) + CW'(1);
    col_x       = CW'(s2_col) + CW'(1);
    tot_out_x   = TCW'(tot_out_sum);
    tot_in_x    = TCW'(tot_in_sum);
    emit        = 1'b0;
    emit_res    = '0;
    if (s2_valid) begin
      case (s2_pass)
        P_DEG: begin
          if (s2_row_end) begin
            emit                = 1'b1;
            emit_res.kind       = KIND_DEGREE;
            emit_res.vertex     = row_x[VERTEX_BITS-1:0];
            emit_res.out_degree = od_x[DEGREE_BITS-1:0];
            emit_res.in_degree  = id_x[DEGREE_BITS-1:0];
            if (s2_all_end) begin
              emit_res.total_out = tot_out_x[TOTAL_BITS-1:0];
              emit_res.total_in  = tot_in_x[TOTAL_BITS-1:0];
              emit_res.last      = 1'b1;
            end
          end
        end
        P_OUT: begin
          emit            = nz_a;
          emit_res.kind   = KIND_OUT_NB;
          emit_res.vertex = col_x[VERTEX_BITS-1:0];
        end
        P_IN: begin
          emit            = nz_b;
          emit_res.kind   = KIND_IN_NB;
          emit_res.vertex = col_x[VERTEX_BITS-1:0];
        end
        default: begin
          emit               = 1'b1;
          emit_res.kind      = KIND_CONN;
          emit_res.vertex    = item_vtx;
          emit_res.connected = nz_a || nz_b;
          emit_res.last      = 1'b1;
        end
      endcase
    end else if (state == ST_MARK) begin
      emit            = 1'b1;
      emit_res.kind   = KIND_END;
      emit_res.vertex = item_vtx;
      emit_res.last   = 1'b1;
    end else if (state == ST_ERROR) begin
      emit          = 1'b1;
      emit_res.kind = KIND_ERROR;
      emit_res.last = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      s2_valid     <= 1'b0;
      res_valid    <= 1'b0;
      vertex_count <= VERTEX_COUNT_RESET;
    end else begin
      state <= state_next;
      if (cfg_write && (paddr[PADDR_BITS-1:2] == REG_VERTEX_COUNT)) begin
        vertex_count <= pwdata[VERTEX_BITS-1:0];
      end
      if (state == ST_CLEAR) clr_addr <= clr_addr + AW'(1);
      if (go) begin
        s2_valid  <= scanning;
        res_valid <= emit;
      end
    end
  end

  // Weight store, two registered read ports
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (go) begin
      rd_a <= mem[{row, col}];
      rd_b <= mem[{col, row}];
    end
  end

  // Scan position, counters and result register
  always_ff @(posedge clk) begin
    if (accept) begin
      row      <= (req.operation == OP_DEGREE) ? '0 : idx_a;
      col      <= (req.operation == OP_CONN) ? idx_b : '0;
      item_vtx <= req.first_vertex;
      od_acc   <= '0;
      id_acc   <= '0;
      tot_out  <= '0;
      tot_in   <= '0;
    end else if (go) begin
      if (scanning) begin
        s2_pass    <= scan_pass;
        s2_row     <= row;
        s2_col     <= col;
        s2_row_end <= col_end;
        s2_all_end <= col_end && row_end;
        if (state == ST_DEGREE) begin
          if (col_end) begin
            col <= '0;
            row <= row + IW'(1);
          end else begin
            col <= col + IW'(1);
          end
        end else if (state == ST_OUT) begin
          col <= col_end ? '0 : col + IW'(1);
        end else if (state == ST_IN) begin
          col <= col + IW'(1);
        end
      end
      if (s2_valid && (s2_pass == P_DEG)) begin
        if (s2_row_end) begin
          od_acc  <= '0;
          id_acc  <= '0;
          tot_out <= tot_out_sum;
          tot_in  <= tot_in_sum;
        end else begin
          od_acc <= od_sum;
          id_acc <= id_sum;
        end
      end
    end
    if (go) res <= emit_res;
  end

`include "adjacency_matrix_graph_engine_macros.svh"

  `AMGE_ASSERT_NOW(a_err_clean, res_valid && (res.kind == KIND_ERROR), (res.vertex == '0) && res.last && !res.connected && (res.out_degree == '0), "error result carries data")
  `AMGE_ASSERT_NOW(a_pipe_idle, s2_valid, state != ST_IDLE, "read pending while idle")
  `AMGE_ASSERT_NOW(a_write_when, mem_we, (state == ST_IDLE) || (state == ST_CLEAR), "store written during a scan")
  `AMGE_ASSERT_NEXT(a_err_emit, (state == ST_ERROR) && go, res_valid && (res.kind == KIND_ERROR), "bad vertex gave no error result")

endmodule

[verif/tb_adjacency_matrix_graph_engine.sv]
// Self-checking testbench for the adjacency matrix graph engine.
module tb_adjacency_matrix_graph_engine;
  import amge_pkg::*;

  localparam int NV             = MAX_VERTICES_DEF;
  localparam int TAIL_CYCLES    = 16;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int LIMIT_CYCLES   = 1_000_000;
  localparam int PHASE_ITEMS    = 28;
  localparam int PHASE_SIZES [4] = '{16, 2, 9, 16};

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_style_t;

  logic                  clk;
  logic                  rst;
  logic                  req_valid;
  logic                  req_stall;
  req_t                  req;
  logic                  res_valid;
  logic                  res_stall;
  res_t                  res;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_BITS-1:0] paddr;
  logic [PDATA_BITS-1:0] pwdata;
  logic [PDATA_BITS-1:0] prdata;
  logic                  pready;

  adjacency_matrix_graph_engine dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow of the graph and the vertex count register
  logic [15:0]  edge_weight [NV][NV];
  logic [4:0]   vertex_count_reg;
  res_t         pending_results [$];
  int           mismatch_count;
  int           burst_left;
  bit           sender_gaps;
  bit           holdoff_req = 1'b0;
  stall_style_t stall_style;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("tb_adjacency_matrix_graph_engine: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Graph predictor
  // ---------------------------------------------------------------------------

  // Count 0 behaves as 1, anything above the matrix size as the full size
  function automatic int active_count();
    if (vertex_count_reg == 0) return 1;
    if (vertex_count_reg > NV) return NV;
    return vertex_count_reg;
  endfunction

  function automatic bit vertex_in_use(int v, int n);
    return v >= 1 && v <= n;
  endfunction

  function automatic void expect_result(kind_t k, int v, int od, int id, int tot_o,
                                        int tot_i, bit conn, bit fin);
    res_t r;
    r.kind       = k;
    r.vertex     = VERTEX_BITS'(v);
    r.out_degree = DEGREE_BITS'(od);
    r.in_degree  = DEGREE_BITS'(id);
    r.total_out  = TOTAL_BITS'(tot_o);
    r.total_in   = TOTAL_BITS'(tot_i);
    r.connected  = conn;
    r.last       = fin;
    pending_results.push_back(r);
  endfunction

  // Update the shadow graph and queue the results of one accepted request
  function automatic void apply_graph_request(req_t r);
    int n, a, b, i, j, od, id, tot_o, tot_i;
    n = active_count();
    a = r.first_vertex;
    b = r.second_vertex;
    case (r.operation)
      OP_INSERT: begin
        if (vertex_in_use(a, n) && vertex_in_use(b, n)) edge_weight[a-1][b-1] = r.weight;
        else expect_result(KIND_ERROR, 0, 0, 0, 0, 0, 1'b0, 1'b1);
      end
      OP_DEGREE: begin
        tot_o = 0;
        tot_i = 0;
        for (i = 0; i < n; i++) begin
          od = 0;
          id = 0;
          for (j = 0; j < n; j++) begin
            if (edge_weight[i][j] != 0) od++;
            if (edge_weight[j][i] != 0) id++;
          end
          tot_o += od;
          tot_i += id;
          if (i == n - 1) expect_result(KIND_DEGREE, i + 1, od, id, tot_o, tot_i, 1'b0, 1'b1);
          else expect_result(KIND_DEGREE, i + 1, od, id, 0, 0, 1'b0, 1'b0);
        end
      end
      OP_LIST: begin
        if (!vertex_in_use(a, n)) begin
          expect_result(KIND_ERROR, 0, 0, 0, 0, 0, 1'b0, 1'b1);
        end else begin
          for (j = 0; j < n; j++)
            if (edge_weight[a-1][j] != 0)
              expect_result(KIND_OUT_NB, j + 1, 0, 0, 0, 0, 1'b0, 1'b0);
          for (j = 0; j < n; j++)
            if (edge_weight[j][a-1] != 0)
              expect_result(KIND_IN_NB, j + 1, 0, 0, 0, 0, 1'b0, 1'b0);
          expect_result(KIND_END, a, 0, 0, 0, 0, 1'b0, 1'b1);
        end
      end
      OP_CONN: begin
        if (!vertex_in_use(a, n) || !vertex_in_use(b, n))
          expect_result(KIND_ERROR, 0, 0, 0, 0, 0, 1'b0, 1'b1);
        else
          expect_result(KIND_CONN, a, 0, 0, 0, 0,
                        edge_weight[a-1][b-1] != 0 || edge_weight[b-1][a-1] != 0, 1'b1);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request building
  // ---------------------------------------------------------------------------

  function automatic req_t graph_request(op_t op, int a, int b, int w);
    req_t r;
    r.operation     = op;
    r.first_vertex  = VERTEX_BITS'(a);
    r.second_vertex = VERTEX_BITS'(b);
    r.weight        = 16'(w);
    return r;
  endfunction

  // Mostly vertices in use, sometimes any 5-bit value
  function automatic int random_vertex(int n);
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 31);
    return $urandom_range(1, n);
  endfunction

  function automatic req_t random_graph_request();
    int n, pick, w;
    n    = active_count();
    pick = $urandom_range(0, 99);
    w    = ($urandom_range(0, 6) == 0) ? 0 : $urandom;
    if (pick < 45) return graph_request(OP_INSERT, random_vertex(n), random_vertex(n), w);
    if (pick < 53) return graph_request(OP_DEGREE, $urandom_range(0, 31),
                                        $urandom_range(0, 31), $urandom);
    if (pick < 75) return graph_request(OP_LIST, random_vertex(n), $urandom_range(0, 31),
                                        $urandom);
    return graph_request(OP_CONN, random_vertex(n), random_vertex(n), $urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // Request sender, register writes and idle wait
  // ---------------------------------------------------------------------------

  // Offer one request, hold it until taken, then maybe close the burst
  task automatic send_request(input req_t r);
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    apply_graph_request(r);
    if (sender_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        req_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Stop offering, wait for every expected result, then let the block go quiet
  task automatic settle_idle();
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_vertex_count(input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_VERTEX_COUNT, 2'b00};
    pwdata  <= PDATA_BITS'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    vertex_count_reg = VERTEX_BITS'(value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result receiver: stall pattern plus the long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    int stall_tick;
    stall_tick = 0;
    forever begin
      @(posedge clk);
      if (holdoff_req) begin
        res_stall <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        holdoff_req = 1'b0;
      end else begin
        stall_tick++;
        case (stall_style)
          STALL_NONE:   res_stall <= 1'b0;
          STALL_RANDOM: res_stall <= ($urandom_range(0, 99) < 35);
          default:      res_stall <= ((stall_tick % 9) < 4);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  function automatic void flag_field(string field, int want, int got);
    mismatch_count++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with nothing pending, expected none, got %h", $time, res);
      end else begin
        want = pending_results.pop_front();
        if (res.kind != want.kind) flag_field("kind", want.kind, res.kind);
        if (res.vertex != want.vertex) flag_field("vertex", want.vertex, res.vertex);
        if (res.out_degree != want.out_degree)
          flag_field("out_degree", want.out_degree, res.out_degree);
        if (res.in_degree != want.in_degree)
          flag_field("in_degree", want.in_degree, res.in_degree);
        if (res.total_out != want.total_out)
          flag_field("total_out", want.total_out, res.total_out);
        if (res.total_in != want.total_in) flag_field("total_in", want.total_in, res.total_in);
        if (res.connected != want.connected)
          flag_field("connected", want.connected, res.connected);
        if (res.last != want.last) flag_field("last", want.last, res.last);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Freshly cleared matrix at the reset count
  task automatic test_empty_graph();
    send_request(graph_request(OP_DEGREE, 0, 0, 0));
    send_request(graph_request(OP_CONN, 1, 16, 0));
    send_request(graph_request(OP_LIST, 1, 0, 0));
    send_request(graph_request(OP_LIST, 16, 0, 0));
    settle_idle();
  endtask

  // Extreme weights, self-loop, both directions, removal by zero weight
  task automatic test_edge_updates();
    send_request(graph_request(OP_INSERT, 1, 16, 32767));
    send_request(graph_request(OP_INSERT, 16, 1, -32768));
    send_request(graph_request(OP_INSERT, 5, 5, 1));
    send_request(graph_request(OP_INSERT, 3, 7, -1));
    send_request(graph_request(OP_LIST, 5, 0, 0));
    send_request(graph_request(OP_LIST, 16, 0, 0));
    send_request(graph_request(OP_CONN, 1, 16, 0));
    send_request(graph_request(OP_CONN, 7, 3, 0));
    send_request(graph_request(OP_INSERT, 3, 7, 0));
    send_request(graph_request(OP_CONN, 3, 7, 0));
    send_request(graph_request(OP_CONN, 5, 5, 0));
    send_request(graph_request(OP_DEGREE, 31, 31, -1));
    settle_idle();
  endtask

  // Vertex 0 and numbers past the count on each operation that takes one
  task automatic test_bad_vertices();
    send_request(graph_request(OP_INSERT, 0, 1, 9));
    send_request(graph_request(OP_INSERT, 1, 17, 9));
    send_request(graph_request(OP_INSERT, 31, 31, 9));
    send_request(graph_request(OP_LIST, 0, 0, 0));
    send_request(graph_request(OP_LIST, 17, 0, 0));
    send_request(graph_request(OP_CONN, 0, 0, 0));
    send_request(graph_request(OP_CONN, 16, 31, 0));
    send_request(graph_request(OP_DEGREE, 0, 0, 0));
    settle_idle();
  endtask

  // Count extremes, clamped values, and matrix entries kept across changes
  task automatic test_vertex_count();
    write_vertex_count(1);
    send_request(graph_request(OP_DEGREE, 0, 0, 0));
    send_request(graph_request(OP_LIST, 1, 0, 0));
    send_request(graph_request(OP_CONN, 1, 1, 0));
    send_request(graph_request(OP_INSERT, 1, 2, 4));
    settle_idle();
    write_vertex_count(0);
    send_request(graph_request(OP_INSERT, 2, 2, 4));
    send_request(graph_request(OP_INSERT, 1, 1, 4));
    send_request(graph_request(OP_DEGREE, 0, 0, 0));
    settle_idle();
    write_vertex_count(31);
    send_request(graph_request(OP_DEGREE, 0, 0, 0));
    send_request(graph_request(OP_LIST, 16, 0, 0));
    send_request(graph_request(OP_CONN, 16, 17, 0));
    settle_idle();
    write_vertex_count(5);
    send_request(graph_request(OP_INSERT, 5, 1, 7));
    send_request(graph_request(OP_INSERT, 6, 1, 7));
    send_request(graph_request(OP_LIST, 5, 0, 0));
    send_request(graph_request(OP_LIST, 1, 0, 0));
    send_request(graph_request(OP_DEGREE, 0, 0, 0));
    settle_idle();
    write_vertex_count(16);
    send_request(graph_request(OP_LIST, 1, 0, 0));
    send_request(graph_request(OP_DEGREE, 0, 0, 0));
    settle_idle();
  endtask

  // Random traffic over several counts and idling styles
  task automatic test_random_traffic();
    int p, k;
    for (p = 0; p < 4; p++) begin
      write_vertex_count(PHASE_SIZES[p]);
      sender_gaps = (p != 0);
      case (p)
        0:       stall_style = STALL_NONE;
        2:       stall_style = STALL_PERIODIC;
        default: stall_style = STALL_RANDOM;
      endcase
      for (k = 0; k < PHASE_ITEMS; k++) send_request(random_graph_request());
      settle_idle();
    end
    sender_gaps = 1'b1;
  endtask

  // Receiver holds off while requests keep coming, so the input backs up
  task automatic test_input_backpressure();
    int k;
    write_vertex_count(16);
    sender_gaps = 1'b0;
    stall_style = STALL_RANDOM;
    holdoff_req = 1'b1;
    send_request(graph_request(OP_DEGREE, 0, 0, 0));
    for (k = 0; k < 11; k++) send_request(random_graph_request());
    settle_idle();
    sender_gaps = 1'b1;
  endtask

  initial begin
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    res_stall <= 1'b0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    foreach (edge_weight[i, j]) edge_weight[i][j] = '0;
    vertex_count_reg = VERTEX_COUNT_RESET;
    mismatch_count   = 0;
    burst_left       = 0;
    sender_gaps      = 1'b1;
    stall_style      = STALL_RANDOM;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_empty_graph();
    test_edge_updates();
    test_bad_vertices();
    test_vertex_count();
    test_random_traffic();
    test_input_backpressure();
    settle_idle();

    if (mismatch_count == 0) begin
      $display("tb_adjacency_matrix_graph_engine: done, clean");
    end else begin
      $display("tb_adjacency_matrix_graph_engine: done, errors");
    end
    $finish;
  end

endmodule
